[src/gld_pkg.sv]
// ----------------------------------------------------------------------------
// gld_pkg
// Shared types and codes for the GIF LZW decoder.
// ----------------------------------------------------------------------------
package gld_pkg;

  localparam int MAX_CODE_BITS = 12;
  localparam int DICT_DEPTH    = 1 << MAX_CODE_BITS;
  localparam int ACC_BITS      = 20;
  localparam int FULL_LEVEL    = ACC_BITS - 8;

  // operation field
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FEED  = 2'd1;
  localparam logic [1:0] OP_PULL  = 2'd2;

  // item kinds after classification
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_FEED  = 2'd1;
  localparam logic [1:0] KIND_PULL  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  // status field
  localparam logic [2:0] ST_PIXEL  = 3'd0;
  localparam logic [2:0] ST_NEED   = 3'd1;
  localparam logic [2:0] ST_ACCEPT = 3'd2;
  localparam logic [2:0] ST_REFUSE = 3'd3;
  localparam logic [2:0] ST_END    = 3'd4;
  localparam logic [2:0] ST_ERROR  = 3'd5;

  // decoder phase
  localparam logic [1:0] PH_FRESH  = 2'd0;
  localparam logic [1:0] PH_NORMAL = 2'd1;
  localparam logic [1:0] PH_END    = 2'd2;
  localparam logic [1:0] PH_ERROR  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } item_t;

endpackage

[src/gld_front.sv]
// ----------------------------------------------------------------------------
// gld_front
// Accepts words, classifies the operation and queues them for the back end.
// ----------------------------------------------------------------------------
module gld_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [7:0]          data_byte,
  output logic                q_valid,
  output gld_pkg::item_t      q_item,
  input  logic                q_pop
);
  import gld_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      incoming;
  logic       push;

  always_comb begin
    incoming.data = data_byte;
    unique case (operation)
      OP_START: incoming.kind = KIND_START;
      OP_FEED:  incoming.kind = KIND_FEED;
      OP_PULL:  incoming.kind = KIND_PULL;
      default:  incoming.kind = KIND_BAD;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

[src/gld_back.sv]
// ----------------------------------------------------------------------------
// gld_back
// Carries out queued words: bit buffer, code unpacking, chain walk over the
// dictionary, expansion stack and the result register.
// ----------------------------------------------------------------------------
module gld_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          root_cfg,
  input  logic                q_valid,
  input  gld_pkg::item_t      q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [7:0]          pixel
);
  import gld_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;

  localparam logic [12:0] DEPTH13 = 13'(DICT_DEPTH);

  logic [19:0] dict_mem  [DICT_DEPTH];
  logic [7:0]  stack_mem [DICT_DEPTH];
  logic [19:0] dict_q;
  logic [7:0]  stack_q;

  logic [2:0]  state;
  logic [3:0]  root_r;
  logic [3:0]  code_width;
  logic [12:0] next_code;
  logic [12:0] width_limit;
  logic [12:0] stack_pointer;
  logic [7:0]  first_symbol;
  logic [11:0] previous_code;
  logic [11:0] in_code;
  logic [11:0] cur;
  logic [19:0] acc;
  logic [4:0]  bit_count;
  logic [7:0]  subblock_remaining;
  logic [1:0]  phase;

  logic [12:0] clr_code;
  logic [19:0] code_mask;
  logic [11:0] code;
  logic [12:0] code13;
  logic [12:0] cur13;
  logic        code_avail;
  logic        cur_is_root;
  logic        sp_full;
  logic [12:0] next_inc;
  logic [3:0]  root_clamped;
  logic        start_item;

  logic        stack_we;
  logic [7:0]  stack_wdata;
  logic        dict_we;

  assign clr_code     = 13'd1 << root_r;
  assign code_mask    = (20'd1 << code_width) - 20'd1;
  assign code         = 12'(acc & code_mask);
  assign code13       = {1'b0, code};
  assign cur13        = {1'b0, cur};
  assign code_avail   = (bit_count >= {1'b0, code_width});
  assign cur_is_root  = (cur13 < clr_code);
  assign sp_full      = stack_pointer[12];
  assign next_inc     = next_code + 13'd1;
  assign root_clamped = (root_cfg < 4'd2) ? 4'd2 : ((root_cfg > 4'd8) ? 4'd8 : root_cfg);
  assign start_item   = (state == S_IDLE) && q_valid && !out_valid;
  assign q_pop        = start_item;

  // memory write controls
  always_comb begin
    stack_we    = 1'b0;
    stack_wdata = first_symbol;
    dict_we     = 1'b0;
    unique case (state)
      S_DECODE: begin
        if (stack_pointer == 13'd0 && code_avail && code13 != clr_code &&
            code13 != clr_code + 13'd1 && phase == PH_NORMAL && code13 == next_code) begin
          stack_we = 1'b1;
        end
      end
      S_WALK: begin
        if (cur_is_root && !sp_full) begin
          stack_we    = 1'b1;
          stack_wdata = cur[7:0];
          dict_we     = (next_code < DEPTH13);
        end
      end
      S_WAIT: begin
        stack_we    = !sp_full;
        stack_wdata = dict_q[7:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_pointer[11:0]] <= stack_wdata;
    end
    stack_q <= stack_mem[12'(stack_pointer - 13'd1)];
    if (dict_we) begin
      dict_mem[next_code[11:0]] <= {previous_code, cur[7:0]};
    end
    dict_q <= dict_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      root_r             <= 4'd8;
      code_width         <= 4'd9;
      next_code          <= 13'd258;
      width_limit        <= 13'd512;
      stack_pointer      <= 13'd0;
      first_symbol       <= 8'd0;
      previous_code      <= 12'd0;
      in_code            <= 12'd0;
      cur                <= 12'd0;
      acc                <= 20'd0;
      bit_count          <= 5'd0;
      subblock_remaining <= 8'd0;
      phase              <= PH_FRESH;
      out_valid          <= 1'b0;
      status             <= ST_NEED;
      pixel              <= 8'd0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start_item) begin
            pixel <= 8'd0;
            case (q_item.kind)
              KIND_START: begin
                out_valid          <= 1'b1;
                root_r             <= root_clamped;
                code_width         <= root_clamped + 4'd1;
                next_code          <= (13'd1 << root_clamped) + 13'd2;
                width_limit        <= 13'd2 << root_clamped;
                stack_pointer      <= 13'd0;
                first_symbol       <= 8'd0;
                previous_code      <= 12'd0;
                acc                <= 20'd0;
                bit_count          <= 5'd0;
                subblock_remaining <= 8'd0;
                phase              <= PH_FRESH;
                status             <= ST_NEED;
              end
              KIND_FEED: begin
                out_valid <= 1'b1;
                if (phase == PH_END || phase == PH_ERROR) begin
                  // drop the byte
                  status <= ST_ACCEPT;
                end else if (subblock_remaining == 8'd0) begin
                  status             <= ST_ACCEPT;
                  subblock_remaining <= q_item.data;
                end else if (bit_count > 5'(FULL_LEVEL)) begin
                  status <= ST_REFUSE;
                end else begin
                  status             <= ST_ACCEPT;
                  acc                <= acc | ({12'd0, q_item.data} << bit_count);
                  bit_count          <= bit_count + 5'd8;
                  subblock_remaining <= subblock_remaining - 8'd1;
                end
              end
              KIND_PULL: begin
                if (phase == PH_END) begin
                  out_valid <= 1'b1;
                  status    <= ST_END;
                end else if (phase == PH_ERROR) begin
                  out_valid <= 1'b1;
                  status    <= ST_ERROR;
                end else begin
                  // hold the result until decoding finishes
                  state <= S_DECODE;
                end
              end
              default: begin
                out_valid <= 1'b1;
                status    <= ST_REFUSE;
              end
            endcase
          end
        end
        S_DECODE: begin
          if (stack_pointer != 13'd0) begin
            stack_pointer <= stack_pointer - 13'd1;
            state         <= S_POP;
          end else if (!code_avail) begin
            out_valid <= 1'b1;
            status    <= ST_NEED;
            pixel     <= 8'd0;
            state     <= S_IDLE;
          end else begin
            acc       <= acc >> code_width;
            bit_count <= bit_count - {1'b0, code_width};
            if (code13 == clr_code) begin
              code_width    <= root_r + 4'd1;
              next_code     <= clr_code + 13'd2;
              width_limit   <= clr_code << 1;
              stack_pointer <= 13'd0;
              phase         <= PH_FRESH;
            end else if (code13 == clr_code + 13'd1) begin
              phase     <= PH_END;
              out_valid <= 1'b1;
              status    <= ST_END;
              pixel     <= 8'd0;
              state     <= S_IDLE;
            end else if (phase == PH_FRESH) begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
              if (code13 >= clr_code) begin
                phase  <= PH_ERROR;
                status <= ST_ERROR;
                pixel  <= 8'd0;
              end else begin
                first_symbol  <= code[7:0];
                previous_code <= code;
                phase         <= PH_NORMAL;
                status        <= ST_PIXEL;
                pixel         <= code[7:0];
              end
            end else if (code13 > next_code) begin
              phase     <= PH_ERROR;
              out_valid <= 1'b1;
              status    <= ST_ERROR;
              pixel     <= 8'd0;
              state     <= S_IDLE;
            end else begin
              in_code <= code;
              if (code13 == next_code) begin
                // KwKwK: repeat the first symbol, walk the previous code
                stack_pointer <= 13'd1;
                cur           <= previous_code;
              end else begin
                cur <= code;
              end
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (!cur_is_root) begin
            if (cur13 < clr_code + 13'd2 || cur13 >= next_code) begin
              phase         <= PH_ERROR;
              stack_pointer <= 13'd0;
              out_valid     <= 1'b1;
              status        <= ST_ERROR;
              pixel         <= 8'd0;
              state         <= S_IDLE;
            end else begin
              state <= S_WAIT;
            end
          end else if (sp_full) begin
            phase         <= PH_ERROR;
            stack_pointer <= 13'd0;
            out_valid     <= 1'b1;
            status        <= ST_ERROR;
            pixel         <= 8'd0;
            state         <= S_IDLE;
          end else begin
            first_symbol  <= cur[7:0];
            stack_pointer <= stack_pointer + 13'd1;
            if (next_code < DEPTH13) begin
              next_code <= next_inc;
              if (next_inc >= width_limit && width_limit < DEPTH13) begin
                width_limit <= width_limit << 1;
                code_width  <= code_width + 4'd1;
              end
            end
            previous_code <= in_code;
            state         <= S_DECODE;
          end
        end
        S_WAIT: begin
          if (sp_full || dict_q[19:8] == cur) begin
            phase         <= PH_ERROR;
            stack_pointer <= 13'd0;
            out_valid     <= 1'b1;
            status        <= ST_ERROR;
            pixel         <= 8'd0;
            state         <= S_IDLE;
          end else begin
            stack_pointer <= stack_pointer + 13'd1;
            cur           <= dict_q[19:8];
            state         <= S_WALK;
          end
        end
        S_POP: begin
          out_valid <= 1'b1;
          status    <= ST_PIXEL;
          pixel     <= stack_q;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/gif_lzw_decoder.sv]
// Start, feed and pulls after end or error are answered from the idle state; a
// pull that expands a code walks its chain through the walk and wait states, and
// stack pixels leave through the pop state. A new word is taken only once the
// last result has left. Reset: synchronous; root width 8, dictionary and stack
// memories not cleared.
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// Pull-style GIF LZW image data decoder with a queued front end.
// ----------------------------------------------------------------------------
module gif_lzw_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [7:0] pixel,
  input  logic       cfg_write_en,
  input  logic [3:0] cfg_write_data
);
  import gld_pkg::*;

  logic [3:0] root_code_width;
  logic       q_valid;
  item_t      q_item;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_code_width <= 4'd8;
    end else if (cfg_write_en) begin
      root_code_width <= cfg_write_data;
    end
  end

  gld_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .data_byte (data_byte),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  gld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .root_cfg  (root_code_width),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .pixel     (pixel)
  );

endmodule

[bench/tb_gif_lzw_decoder.sv]
// ----------------------------------------------------------------------------
// tb_gif_lzw_decoder
// Self-checking bench for the GIF LZW decoder. It starts with a short table
// of directed words: reset state, unused operation, terminators, end of image,
// sticky error and buffer refusal. It then builds LZW code streams, packs them
// LSB first and cuts them into sub-blocks, and feeds and pulls them against a
// cycle-free model of the decoder. The streams cover clear codes, the KwKwK
// case, width growth, corrupted codes and early restarts. Both handshakes
// stall at random.
// ----------------------------------------------------------------------------
module tb_gif_lzw_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import gld_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         LIMIT     = 1500000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] operation = OP_START;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] status;
  logic [7:0] pixel;
  logic       cfg_write_en = 1'b0;
  logic [3:0] cfg_write_data = 4'd0;

  gif_lzw_decoder u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .pixel(pixel),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [2:0] st;
    logic [7:0] px;
  } answer_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
    bit         fixed;
    logic [2:0] st;
    logic [7:0] px;
  } row_t;

  answer_t     pending_answers[$];
  int          fail_count = 0;
  int          n_items = 0;
  int          n_pixels = 0;
  int          n_images = 0;
  bit          quiet = 1'b0;
  longint      cycles = 0;

  // decoder model state
  logic [11:0] m_prefix[DICT_DEPTH];
  logic [7:0]  m_suffix[DICT_DEPTH];
  logic [7:0]  m_stack[DICT_DEPTH];
  int unsigned m_sp, m_width, m_next, m_limit, m_first, m_prev;
  int unsigned m_acc, m_bits, m_remain, m_clear;
  logic [1:0]  m_phase;
  logic [3:0]  m_root_reg;

  logic [7:0]  stream_bytes[$];

  function automatic int unsigned eff_root(logic [3:0] r);
    if (r < 2) return 2;
    if (r > 8) return 8;
    return {28'd0, r};
  endfunction

  function automatic void restart_dict();
    m_width = 0;
    m_next  = m_clear + 2;
    m_limit = 2 * m_clear;
    m_sp    = 0;
    m_phase = PH_FRESH;
  endfunction

  function automatic void begin_image();
    int unsigned r;
    r = eff_root(m_root_reg);
    m_clear = 1 << r;
    restart_dict();
    m_width  = r + 1;
    m_first  = 0;
    m_prev   = 0;
    m_acc    = 0;
    m_bits   = 0;
    m_remain = 0;
  endfunction

  function automatic bit push_sym(int unsigned s);
    if (m_sp >= DICT_DEPTH) return 1'b0;
    m_stack[m_sp] = s[7:0];
    m_sp++;
    return 1'b1;
  endfunction

  function automatic bit expand_code(int unsigned code);
    int unsigned in_code;
    in_code = code;
    if (code >= m_next) begin
      if (code != m_next) return 1'b0;
      if (!push_sym(m_first)) return 1'b0;
      code = m_prev;
    end
    while (code >= m_clear) begin
      if (code < m_clear + 2 || code >= m_next || code >= DICT_DEPTH) return 1'b0;
      if (!push_sym(m_suffix[code])) return 1'b0;
      if (m_prefix[code] == code) return 1'b0;
      code = m_prefix[code];
    end
    m_first = code;
    if (!push_sym(code)) return 1'b0;
    if (m_next < DICT_DEPTH) begin
      m_prefix[m_next] = m_prev[11:0];
      m_suffix[m_next] = m_first[7:0];
      m_next++;
      if (m_next >= m_limit && m_limit < DICT_DEPTH) begin
        m_limit = m_limit * 2;
        m_width++;
      end
    end
    m_prev = in_code & 12'hFFF;
    return 1'b1;
  endfunction

  function automatic logic [2:0] pull_pixel(output logic [7:0] px);
    int unsigned code;
    px = 8'h00;
    if (m_phase == PH_END) return ST_END;
    if (m_phase == PH_ERROR) return ST_ERROR;
    forever begin
      if (m_sp > 0) begin
        m_sp--;
        px = m_stack[m_sp & (DICT_DEPTH - 1)];
        return ST_PIXEL;
      end
      if (m_width == 0 || m_width > MAX_CODE_BITS || m_bits < m_width) return ST_NEED;
      code   = m_acc & ((1 << m_width) - 1);
      m_acc  = m_acc >> m_width;
      m_bits = m_bits - m_width;
      if (code == m_clear) begin
        restart_dict();
        m_width = $clog2(m_clear) + 1;
        continue;
      end
      if (code == m_clear + 1) begin
        m_phase = PH_END;
        return ST_END;
      end
      if (m_phase == PH_FRESH) begin
        if (code >= m_clear) begin
          m_phase = PH_ERROR;
          return ST_ERROR;
        end
        m_first = code;
        m_prev  = code;
        m_phase = PH_NORMAL;
        px = code[7:0];
        return ST_PIXEL;
      end
      if (!expand_code(code)) begin
        m_phase = PH_ERROR;
        m_sp = 0;
        return ST_ERROR;
      end
    end
  endfunction

  function automatic logic [2:0] feed_byte(logic [7:0] b);
    if (m_phase == PH_END || m_phase == PH_ERROR) return ST_ACCEPT;
    if (m_remain == 0) begin
      m_remain = b;
      return ST_ACCEPT;
    end
    if (m_bits + 8 > ACC_BITS) return ST_REFUSE;
    m_acc  = (m_acc | (int'(b) << m_bits)) & 32'hFFFFF;
    m_bits += 8;
    m_remain--;
    return ST_ACCEPT;
  endfunction

  function automatic answer_t decode_word(logic [1:0] op, logic [7:0] b);
    answer_t a;
    a.px = 8'h00;
    case (op)
      OP_START: begin
        begin_image();
        a.st = ST_NEED;
      end
      OP_FEED: a.st = feed_byte(b);
      OP_PULL: a.st = pull_pixel(a.px);
      default: a.st = ST_REFUSE;
    endcase
    if (a.st != ST_PIXEL) a.px = 8'h00;
    return a;
  endfunction

  // drive one word, expectation queued beforehand; called at a rising edge
  task automatic send_word(input logic [1:0] op, input logic [7:0] b, input bit fixed,
                           input answer_t typed, output answer_t got);
    got = decode_word(op, b);
    if (fixed && got != typed) begin
      $display("%0t typed answer differs: expected st=%0d px=%0d actual st=%0d px=%0d",
               $time, typed.st, typed.px, got.st, got.px);
      fail_count++;
    end
    pending_answers.push_back(fixed ? typed : got);
    in_valid  <= 1'b1;
    operation <= op;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send(input logic [1:0] op, input logic [7:0] b, output answer_t got);
    send_word(op, b, 1'b0, '0, got);
  endtask

  // wait until every answer has come, then write the root width
  task automatic write_root(input logic [3:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    m_root_reg = v;
  endtask

  // LZW code stream for one image, packed LSB first, cut into sub-blocks
  task automatic build_stream(input int unsigned root, input int ncodes, input bit long_run);
    longint unsigned pk;
    int          pkb, gw, gn, gl, bad_at, rr, n;
    int unsigned clr, c;
    bit          fresh;
    logic [7:0]  pay[$];
    clr = 1 << root;
    gw = root + 1; gn = clr + 2; gl = 2 * clr; fresh = 1'b1;
    pk = 0; pkb = 0;
    bad_at = (!long_run && $urandom_range(0, 5) == 0) ? $urandom_range(0, ncodes) : -1;
    for (int i = -1; i <= ncodes; i++) begin
      rr = $urandom_range(0, 99);
      if (i == -1) begin
        if (rr < 50) continue;
        c = clr;
      end else if (i == ncodes) begin
        if (rr < 8) break;
        c = clr + 1;
      end else if (i == bad_at) begin
        c = $urandom & ((1 << gw) - 1);
      end else if (fresh) begin
        c = (rr < 3) ? clr : $urandom_range(0, clr - 1);
      end else if (rr < (long_run ? 0 : 4)) begin
        c = clr;
      end else if (rr < (long_run ? 90 : 30)) begin
        c = $urandom_range(0, clr - 1);
      end else if (rr < (long_run ? 93 : 45) && gn < DICT_DEPTH) begin
        c = gn;
      end else begin
        c = $urandom_range(0, gn - 1);
        if (c == clr || c == clr + 1) c = 0;
      end
      pk  = pk | (longint'(c) << pkb);
      pkb += gw;
      while (pkb >= 8) begin
        pay.push_back(pk[7:0]);
        pk = pk >> 8;
        pkb -= 8;
      end
      if (c == clr) begin
        gw = root + 1; gn = clr + 2; gl = 2 * clr; fresh = 1'b1;
      end else if (fresh) begin
        fresh = 1'b0;
      end else if (gn < DICT_DEPTH) begin
        gn++;
        if (gn >= gl && gl < DICT_DEPTH) begin
          gl = gl * 2;
          gw++;
        end
      end
    end
    if (pkb > 0) pay.push_back(8'((pk | ($urandom << pkb)) & 8'hFF));
    stream_bytes.delete();
    while (pay.size() != 0) begin
      n = $urandom_range(1, long_run ? 255 : 12);
      if (n > pay.size()) n = pay.size();
      stream_bytes.push_back(n[7:0]);
      repeat (n) stream_bytes.push_back(pay.pop_front());
    end
    stream_bytes.push_back(8'h00);
  endtask

  task automatic run_image(input int ncodes, input bit long_run);
    answer_t got;
    bit      useful;
    int      rr;
    send(OP_START, 8'h00, got);
    n_images++;
    build_stream(eff_root(m_root_reg), ncodes, long_run);
    forever begin
      rr = $urandom_range(0, 999);
      useful = (m_sp > 0) || (m_bits >= m_width);
      if (m_phase == PH_END || m_phase == PH_ERROR) begin
        if (rr < 250) send(OP_PULL, 8'h00, got);
        else if (rr < 700 && stream_bytes.size() != 0)
          send(OP_FEED, stream_bytes.pop_front(), got);
        else break;
      end else if (!long_run && rr < 3) begin
        send(OP_UNUSED, 8'($urandom), got);
      end else if (!long_run && rr < 5) begin
        // restart in the middle of an image; the rest is dropped
        send(OP_START, 8'($urandom), got);
        break;
      end else if (stream_bytes.size() == 0 && !useful) begin
        send(OP_PULL, 8'h00, got);
        break;
      end else if (stream_bytes.size() != 0 && (!useful || rr < 300)) begin
        send(OP_FEED, stream_bytes[0], got);
        if (got.st != ST_REFUSE) void'(stream_bytes.pop_front());
      end else begin
        send(OP_PULL, 8'($urandom), got);
        if (got.st == ST_PIXEL) n_pixels++;
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected word: actual st=%0d px=%0d", $time, status, pixel);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.st) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, want.st, status);
          fail_count++;
        end
        if (pixel !== want.px) begin
          $display("%0t pixel mismatch: expected %0d actual %0d", $time, want.px, pixel);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  row_t        rows[26];
  logic [3:0]  roots[4] = '{4'd2, 4'd8, 4'd0, 4'd15};
  answer_t     got, typed;
  int          base;

  initial begin
    rows = '{
      '{OP_PULL,   8'h00, 1, ST_NEED,   8'd0},
      '{OP_UNUSED, 8'hAA, 1, ST_REFUSE, 8'd0},
      '{OP_START,  8'h00, 1, ST_NEED,   8'd0},
      '{OP_FEED,   8'h00, 1, ST_ACCEPT, 8'd0},
      '{OP_FEED,   8'h04, 1, ST_ACCEPT, 8'd0},
      '{OP_FEED,   8'hFF, 1, ST_ACCEPT, 8'd0},
      '{OP_FEED,   8'h00, 1, ST_ACCEPT, 8'd0},
      '{OP_PULL,   8'h00, 1, ST_PIXEL,  8'd255},
      '{OP_FEED,   8'h00, 0, ST_ACCEPT, 8'd0},
      '{OP_FEED,   8'h00, 0, ST_REFUSE, 8'd0},
      '{OP_PULL,   8'h00, 0, ST_PIXEL,  8'd0},
      '{OP_PULL,   8'h00, 0, ST_NEED,   8'd0},
      '{OP_START,  8'hFF, 1, ST_NEED,   8'd0},
      '{OP_FEED,   8'h02, 1, ST_ACCEPT, 8'd0},
      '{OP_FEED,   8'h01, 1, ST_ACCEPT, 8'd0},
      '{OP_FEED,   8'h01, 1, ST_ACCEPT, 8'd0},
      '{OP_PULL,   8'h00, 1, ST_END,    8'd0},
      '{OP_PULL,   8'h00, 1, ST_END,    8'd0},
      '{OP_FEED,   8'h55, 1, ST_ACCEPT, 8'd0},
      '{OP_START,  8'h00, 1, ST_NEED,   8'd0},
      '{OP_FEED,   8'h03, 1, ST_ACCEPT, 8'd0},
      '{OP_FEED,   8'hFF, 1, ST_ACCEPT, 8'd0},
      '{OP_FEED,   8'hFF, 1, ST_ACCEPT, 8'd0},
      '{OP_FEED,   8'h00, 1, ST_REFUSE, 8'd0},
      '{OP_PULL,   8'h00, 1, ST_ERROR,  8'd0},
      '{OP_PULL,   8'h00, 1, ST_ERROR,  8'd0}
    };
    m_root_reg = 4'd8;
    begin_image();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      typed.st = rows[i].st;
      typed.px = rows[i].px;
      send_word(rows[i].op, rows[i].data, rows[i].fixed, typed, got);
    end

    base = n_items;
    for (int k = 0; n_items - base < 1250; k++) begin
      quiet = (n_items - base > 1050);
      if (k < 4) write_root(roots[k]);
      else if ($urandom_range(0, 2) == 0)
        write_root(4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(2, 8)));
      run_image((n_items - base < 900 && $urandom_range(0, 9) == 0) ?
                $urandom_range(100, 300) : $urandom_range(3, 40), 1'b0);
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d words over %0d images, %0d pixels from the random streams,",
             n_items, n_images, n_pixels);
    $display("including clear codes, KwKwK codes, width growth, errors and refusals.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/gld_pkg.sv
src/gld_front.sv
src/gld_back.sv
src/gif_lzw_decoder.sv
bench/tb_gif_lzw_decoder.sv
